@@ hw/rtl/ctnp_pkg.sv @@
// Constants, phase codes and character classes for the colon triple number parser.
`default_nettype none

package ctnp_pkg;

    localparam int MAX_LENGTH = 4096;
    localparam int POS_W      = 13;
    localparam int VAL_W      = 32;
    localparam int MIN_REM    = 5;
    localparam int N_FIELDS   = 3;
    localparam int IDX_W      = 2;
    localparam int OUT_DATA_W = 112;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LENGTH);

    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_FIELD = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_FIELD = IDX_W'(N_FIELDS - 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    function automatic logic is_white(input logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        return b inside {CH_COLON, CH_SPACE, CH_TAB, CH_LF};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v >= MAX_POS) ? MAX_POS : v + POS_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/colon_triple_number_parser.sv @@
// Top level: streaming parser for three decimal fields separated by colon, space, tab or line feed.
//
//  channel | dir | tdata (low bit up)                         | tuser / tlast
//  s_axis  | in  | text_byte[7:0]                             | tlast = is_last
//  m_axis  | out | book[31:0] chapter[63:32] verse[95:64]     | tuser = found
//          |     | consumed_length[108:96], zero pad to 111   |
//
// One byte per cycle while s_axis_tready is high; each accepted byte updates the parse state.
// The last byte of a string loads the result register at its accepting edge;
// the result item is offered from the next cycle.
// Critical path: multiply-by-ten accumulate and 32-bit overflow check.
// aresetn (synchronous) returns the parser to the leading whitespace phase.
// A held result stalls s_axis only while m_axis_tready is low.
`default_nettype none

module colon_triple_number_parser
    import ctnp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // text_byte
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // book, chapter, verse, consumed_length
    output logic                       m_axis_tuser    // found
);

    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic             has_digit_reg, has_digit_next;
    logic [VAL_W-1:0] saved_reg [N_FIELDS];
    logic [VAL_W-1:0] saved_next [N_FIELDS];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] lead_reg, lead_next;
    logic [POS_W-1:0] eoff_reg, eoff_next;
    logic             failed_reg, failed_next;

    logic             mvalid_reg, mvalid_next;
    logic             found_reg, found_next;
    logic [VAL_W-1:0] book_reg, book_next;
    logic [VAL_W-1:0] chap_reg, chap_next;
    logic [VAL_W-1:0] verse_reg, verse_next;
    logic [POS_W-1:0] cons_reg, cons_next;

    logic [7:0]       b;
    logic             in_acc;
    logic             field_act;
    logic [VAL_W+3:0] prod;
    logic             fail_end;
    logic [1:0]       phase_end;
    logic [POS_W-1:0] eoff_end;
    logic [VAL_W-1:0] verse_end;
    logic [POS_W-1:0] rem;
    logic             ok;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !mvalid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign prod          = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                         + (VAL_W+4)'(b - CH_ZERO);

    always_comb begin
        phase_next     = phase_reg;
        fidx_next      = fidx_reg;
        acc_next       = acc_reg;
        has_digit_next = has_digit_reg;
        saved_next     = saved_reg;
        lead_next      = lead_reg;
        eoff_next      = eoff_reg;
        failed_next    = failed_reg;
        pos_next       = sat_inc(pos_reg);
        field_act      = 1'b0;

        if (phase_reg == PH_LEAD) begin
            if (is_white(b)) begin
                lead_next = sat_inc(lead_reg);
            end else begin
                phase_next = PH_FIELD;
                field_act  = 1'b1;
            end
        end else if (phase_reg == PH_FIELD) begin
            field_act = 1'b1;
        end

        if (field_act) begin
            if (is_delim(b)) begin
                if (!has_digit_reg) begin
                    failed_next = 1'b1;
                    phase_next  = PH_DONE;
                end else begin
                    for (int k = 0; k < N_FIELDS; k++) begin
                        if (fidx_reg == IDX_W'(k)) saved_next[k] = acc_reg;
                    end
                    if (fidx_reg == LAST_FIELD) begin
                        eoff_next  = pos_reg;
                        phase_next = PH_TRAIL;
                    end else begin
                        fidx_next      = fidx_reg + IDX_W'(1);
                        acc_next       = '0;
                        has_digit_next = 1'b0;
                    end
                end
            end else if (is_digit(b)) begin
                acc_next       = prod[VAL_W-1:0];
                has_digit_next = 1'b1;
                if (prod[VAL_W+3:VAL_W] != 4'd0) begin
                    failed_next = 1'b1;
                    phase_next  = PH_DONE;
                end
            end else begin
                failed_next = 1'b1;
                phase_next  = PH_DONE;
            end
        end else if (phase_reg == PH_TRAIL) begin
            if (is_white(b)) begin
                eoff_next = sat_inc(eoff_reg);
            end else begin
                phase_next = PH_DONE;
            end
        end
    end

    // end of string: third field may close here
    always_comb begin
        fail_end  = failed_next;
        phase_end = phase_next;
        eoff_end  = eoff_next;
        verse_end = saved_next[2];
        if (!failed_next && phase_next == PH_FIELD) begin
            if (fidx_next == LAST_FIELD && has_digit_next) begin
                verse_end = acc_next;
                eoff_end  = pos_next;
                phase_end = PH_DONE;
            end else begin
                fail_end  = 1'b1;
                phase_end = PH_DONE;
            end
        end
        rem = pos_next - lead_next;
        ok  = !fail_end && phase_end != PH_LEAD;

        found_next = found_reg;
        book_next  = book_reg;
        chap_next  = chap_reg;
        verse_next = verse_reg;
        cons_next  = cons_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        if (in_acc && s_axis_tlast) begin
            mvalid_next = 1'b1;
            if (rem < POS_W'(MIN_REM)) begin
                found_next = 1'b0;
                book_next  = '0;
                chap_next  = '0;
                verse_next = '0;
                cons_next  = '0;
            end else begin
                found_next = ok;
                book_next  = saved_next[0];
                chap_next  = saved_next[1];
                verse_next = verse_end;
                cons_next  = ok ? eoff_end : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_acc && s_axis_tlast)) begin
            phase_reg     <= PH_LEAD;
            fidx_reg      <= '0;
            acc_reg       <= '0;
            has_digit_reg <= 1'b0;
            pos_reg       <= '0;
            lead_reg      <= '0;
            eoff_reg      <= '0;
            failed_reg    <= 1'b0;
            for (int k = 0; k < N_FIELDS; k++) saved_reg[k] <= '0;
        end else if (in_acc) begin
            phase_reg     <= phase_next;
            fidx_reg      <= fidx_next;
            acc_reg       <= acc_next;
            has_digit_reg <= has_digit_next;
            pos_reg       <= pos_next;
            lead_reg      <= lead_next;
            eoff_reg      <= eoff_next;
            failed_reg    <= failed_next;
            saved_reg     <= saved_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else begin
            mvalid_reg <= mvalid_next;
        end
        found_reg <= found_next;
        book_reg  <= book_next;
        chap_reg  <= chap_next;
        verse_reg <= verse_next;
        cons_reg  <= cons_next;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tuser  = found_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - 3*VAL_W - POS_W)'(0), cons_reg,
                            verse_reg, chap_reg, book_reg};

    a_fail_done: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |-> phase_reg == PH_DONE)
        else $error("failure flag set outside done phase");

    a_fidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fidx_reg <= LAST_FIELD)
        else $error("field index past last field");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !found_reg) |-> cons_reg == '0)
        else $error("consumed length set without a match");

    a_hit_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && found_reg) |-> (cons_reg >= POS_W'(MIN_REM) && cons_reg <= MAX_POS))
        else $error("consumed length out of range on a match");

    a_lead_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        lead_reg <= pos_reg)
        else $error("leading skip count ahead of byte position");

endmodule

`default_nettype wire
